// ===== src/sts_pkg.sv =====
// Package for the s-expression token scanner.
// Holds token kind codes, scan mode codes, character constants and payload types.
// No dependencies.
package sts_pkg;

  typedef enum logic [3:0] {
    KIND_LPAREN = 4'd0,
    KIND_RPAREN = 4'd1,
    KIND_SCHAR  = 4'd2,
    KIND_SEND   = 4'd3,
    KIND_ICHAR  = 4'd4,
    KIND_IEND   = 4'd5,
    KIND_NUMBER = 4'd6,
    KIND_EOF    = 4'd7,
    KIND_ERROR  = 4'd8
  } token_kind_e;

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_STRING = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_MINUS  = 3'd3;
  localparam logic [2:0] MODE_IDENT  = 3'd4;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  text_char;
    logic [31:0] number_value;
  } token_t;

  typedef struct packed {
    token_t [MaxResults-1:0] tok;
    logic [1:0]              count;
  } group_t;

  function automatic token_t mk_tok(token_kind_e kind, logic [7:0] ch, logic [31:0] num);
    token_t t;
    t.kind         = kind;
    t.text_char    = ch;
    t.number_value = num;
    return t;
  endfunction

endpackage

// ===== src/sts_if.sv =====
// Handshake interfaces for the s-expression token scanner.
// Byte channel in, token channel out; depends on nothing else.
interface sts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sts_token_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  token_kind;
  logic        [7:0]  text_char;
  logic signed [31:0] number_value;
  logic               last;

  modport source (output valid, output token_kind, output text_char, output number_value,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input text_char, input number_value,
                  input last, output ready);
endinterface

// ===== src/sts_lexer_core.sv =====
// Scan state registers and the per-byte next-state and token logic.
// Depends on sts_pkg for codes and the token group type.
module sts_lexer_core #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_input_i,
  output sts_pkg::group_t    group_o
);

  localparam int unsigned MagBits = NUMBER_BITS - 1;

  logic [2:0]         mode_q, mode_d;
  logic [MagBits-1:0] mag_q, mag_d;
  logic               neg_q, neg_d;

  logic               is_blank, is_digit;
  logic [3:0]         digit;
  logic [MagBits-1:0] base_mag, dig_mag;
  logic [MagBits+3:0] prod;
  logic [NUMBER_BITS-1:0] num_nb;
  logic [NUMBER_BITS+31:0] num_ext;
  logic [31:0]        num_out;

  sts_pkg::token_t    idle_tok;
  logic               idle_cnt;
  logic [2:0]         idle_mode;
  logic [MagBits-1:0] idle_mag;
  logic               idle_neg;

  sts_pkg::group_t    grp;

  assign is_blank = (in_byte_i == sts_pkg::CHAR_SPACE) || (in_byte_i == sts_pkg::CHAR_TAB) ||
                    (in_byte_i == sts_pkg::CHAR_LF);
  assign is_digit = (in_byte_i >= sts_pkg::CHAR_ZERO) && (in_byte_i <= sts_pkg::CHAR_NINE);
  assign digit    = in_byte_i[3:0];

  // Ten times the magnitude plus the digit; any bit above the magnitude width means saturation.
  assign base_mag = (mode_q == sts_pkg::MODE_NUMBER) ? mag_q : '0;
  assign prod     = {1'b0, base_mag, 3'b000} + {3'b000, base_mag, 1'b0}
                  + (MagBits+4)'(digit);
  assign dig_mag  = (|prod[MagBits+3:MagBits]) ? {MagBits{1'b1}} : prod[MagBits-1:0];

  assign num_nb  = neg_q ? (NUMBER_BITS'(0) - {1'b0, mag_q}) : {1'b0, mag_q};
  assign num_ext = {32'd0, num_nb};
  assign num_out = num_ext[31:0];

  always_comb begin
    idle_tok  = sts_pkg::mk_tok(sts_pkg::KIND_LPAREN, 8'd0, 32'd0);
    idle_cnt  = 1'b0;
    idle_mode = sts_pkg::MODE_IDLE;
    idle_mag  = '0;
    idle_neg  = 1'b0;
    priority if (is_blank) begin
      idle_cnt = 1'b0;
    end else if (in_byte_i == sts_pkg::CHAR_LPAREN) begin
      idle_cnt = 1'b1;
    end else if (in_byte_i == sts_pkg::CHAR_RPAREN) begin
      idle_tok = sts_pkg::mk_tok(sts_pkg::KIND_RPAREN, 8'd0, 32'd0);
      idle_cnt = 1'b1;
    end else if (in_byte_i == sts_pkg::CHAR_QUOTE) begin
      idle_mode = sts_pkg::MODE_STRING;
    end else if (is_digit) begin
      idle_mode = sts_pkg::MODE_NUMBER;
      idle_mag  = dig_mag;
    end else if (in_byte_i == sts_pkg::CHAR_MINUS) begin
      idle_mode = sts_pkg::MODE_MINUS;
    end else begin
      idle_mode = sts_pkg::MODE_IDENT;
      idle_tok  = sts_pkg::mk_tok(sts_pkg::KIND_ICHAR, in_byte_i, 32'd0);
      idle_cnt  = 1'b1;
    end
  end

  always_comb begin
    grp        = '0;
    mode_d     = mode_q;
    mag_d      = mag_q;
    neg_d      = neg_q;
    if (end_of_input_i) begin
      mode_d = sts_pkg::MODE_IDLE;
      mag_d  = '0;
      neg_d  = 1'b0;
      unique case (mode_q)
        sts_pkg::MODE_STRING: begin
          grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_ERROR, 8'd0, 32'd0);
          grp.count  = 2'd1;
        end
        sts_pkg::MODE_NUMBER: begin
          grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_NUMBER, 8'd0, num_out);
          grp.tok[1] = sts_pkg::mk_tok(sts_pkg::KIND_EOF, 8'd0, 32'd0);
          grp.count  = 2'd2;
        end
        sts_pkg::MODE_MINUS: begin
          grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_ICHAR, sts_pkg::CHAR_MINUS, 32'd0);
          grp.tok[1] = sts_pkg::mk_tok(sts_pkg::KIND_IEND, 8'd0, 32'd0);
          grp.tok[2] = sts_pkg::mk_tok(sts_pkg::KIND_EOF, 8'd0, 32'd0);
          grp.count  = 2'd3;
        end
        sts_pkg::MODE_IDENT: begin
          grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_IEND, 8'd0, 32'd0);
          grp.tok[1] = sts_pkg::mk_tok(sts_pkg::KIND_EOF, 8'd0, 32'd0);
          grp.count  = 2'd2;
        end
        default: begin
          grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_EOF, 8'd0, 32'd0);
          grp.count  = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_q)
        sts_pkg::MODE_STRING: begin
          if (in_byte_i == sts_pkg::CHAR_QUOTE) begin
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_SEND, 8'd0, 32'd0);
            mode_d     = sts_pkg::MODE_IDLE;
          end else begin
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_SCHAR, in_byte_i, 32'd0);
          end
          grp.count = 2'd1;
        end
        sts_pkg::MODE_NUMBER: begin
          if (is_digit) begin
            mag_d = dig_mag;
          end else begin
            // The byte that ends a number is scanned again as if between tokens.
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_NUMBER, 8'd0, num_out);
            grp.tok[1] = idle_tok;
            grp.count  = idle_cnt ? 2'd2 : 2'd1;
            mode_d     = idle_mode;
            mag_d      = idle_mag;
            neg_d      = idle_neg;
          end
        end
        sts_pkg::MODE_MINUS: begin
          if (is_digit) begin
            mode_d = sts_pkg::MODE_NUMBER;
            mag_d  = dig_mag;
            neg_d  = 1'b1;
          end else if (is_blank) begin
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_ICHAR, sts_pkg::CHAR_MINUS, 32'd0);
            grp.tok[1] = sts_pkg::mk_tok(sts_pkg::KIND_IEND, 8'd0, 32'd0);
            grp.count  = 2'd2;
            mode_d     = sts_pkg::MODE_IDLE;
          end else begin
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_ICHAR, sts_pkg::CHAR_MINUS, 32'd0);
            grp.tok[1] = sts_pkg::mk_tok(sts_pkg::KIND_ICHAR, in_byte_i, 32'd0);
            grp.count  = 2'd2;
            mode_d     = sts_pkg::MODE_IDENT;
          end
        end
        sts_pkg::MODE_IDENT: begin
          if (is_blank) begin
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_IEND, 8'd0, 32'd0);
            mode_d     = sts_pkg::MODE_IDLE;
          end else begin
            grp.tok[0] = sts_pkg::mk_tok(sts_pkg::KIND_ICHAR, in_byte_i, 32'd0);
          end
          grp.count = 2'd1;
        end
        default: begin
          grp.tok[0] = idle_tok;
          grp.count  = {1'b0, idle_cnt};
          mode_d     = idle_mode;
          mag_d      = idle_mag;
          neg_d      = idle_neg;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sts_pkg::MODE_IDLE;
      mag_q  <= '0;
      neg_q  <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d;
      mag_q  <= mag_d;
      neg_q  <= neg_d;
    end
  end

  assign group_o = grp;

endmodule

// ===== src/sts_result_queue.sv =====
// Result register for one group of up to three tokens, sent one transfer at a time.
// Depends on sts_pkg for the token and group types.
module sts_result_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  sts_pkg::group_t group_i,
  output logic            in_ready_o,
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output sts_pkg::token_t token_o,
  output logic            last_o
);

  sts_pkg::token_t [sts_pkg::MaxResults-1:0] tok_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       pop;

  assign tok_valid_o = (cnt_q != 2'd0);
  assign last_o      = (idx_q == (cnt_q - 2'd1));
  assign token_o     = tok_q[idx_q];
  assign pop         = tok_valid_o && tok_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || (pop && last_o);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    priority if (load_i) begin
      cnt_d = group_i.count;
      idx_d = 2'd0;
    end else if (pop && last_o) begin
      cnt_d = 2'd0;
      idx_d = 2'd0;
    end else if (pop) begin
      idx_d = idx_q + 2'd1;
    end else begin
      cnt_d = cnt_q;
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= group_i.tok;
    end
  end

endmodule

// ===== src/sexpr_token_scanner.sv =====
// Top level of the s-expression token scanner.
// Uses sts_pkg, sts_if, sts_lexer_core and sts_result_queue.
//
//   port     | dir | contents
//   byte_i   | in  | in_byte, end_of_input
//   token_o  | out | token_kind, text_char, number_value, last
//
// A byte transfer is taken in the cycle its tokens are computed; they land in the
// result register, and the first is offered in the next cycle.
// A byte producing zero or one token is taken every cycle while the token output is ready;
// one producing more holds the input until the single token output port takes its last token.
// A stalled token output holds the input off once the result register is full.
// Reset puts the scanner between tokens with an empty result register.
module sexpr_token_scanner #(
  parameter int unsigned NUMBER_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sts_byte_if.sink    byte_i,
  sts_token_if.source token_o
);

  sts_pkg::group_t group;
  sts_pkg::token_t tok;
  logic            accept;
  logic            in_ready;

  assign accept       = byte_i.valid && in_ready;
  assign byte_i.ready = in_ready;

  sts_lexer_core #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (accept),
    .in_byte_i      (byte_i.in_byte),
    .end_of_input_i (byte_i.end_of_input),
    .group_o        (group)
  );

  sts_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .group_i     (group),
    .in_ready_o  (in_ready),
    .tok_valid_o (token_o.valid),
    .tok_ready_i (token_o.ready),
    .token_o     (tok),
    .last_o      (token_o.last)
  );

  assign token_o.token_kind   = tok.kind;
  assign token_o.text_char    = tok.text_char;
  assign token_o.number_value = tok.number_value;

endmodule
